// File: rtl/cda_pkg.sv
// Shared types, widths, codes and calendar tables for the calendar date arithmetic block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cda_pkg;

   // field widths
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_IN_W   = 14;
   localparam int CNT_W       = 22;
   localparam int STATUS_W    = 2;
   localparam int DOY_W       = 9;   // zero-based day of year, 0..365
   localparam int WORK_W      = 23;  // day of year plus day count, or the year-length sum

   localparam int MAX_YEAR_DEFAULT = 9999;
   localparam int DEFAULT_YEAR     = 1970;

   localparam logic [CNT_W-1:0]  DAYS_MAX  = '1;
   // once the year-length sum passes this, the difference is saturated for sure
   localparam logic [WORK_W-1:0] ACC_LIMIT = WORK_W'(DAYS_MAX) + WORK_W'(366);

   // y / 100 == (y * DIV100_MUL) >> DIV100_SHIFT, exact for y below 91180
   localparam int DIV100_MUL   = 83887;
   localparam int DIV100_MUL_W = 17;
   localparam int DIV100_SHIFT = 23;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_W-1:0] OP_DIV_Q      = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV_R      = 4'd3;
   localparam logic [OP_W-1:0] OP_DOY_SECOND = 4'd4;
   localparam logic [OP_W-1:0] OP_DOY_FIRST  = 4'd5;
   localparam logic [OP_W-1:0] OP_YEAR_ADD   = 4'd6;
   localparam logic [OP_W-1:0] OP_YEAR_DIFF  = 4'd7;
   localparam logic [OP_W-1:0] OP_MONTH      = 4'd8;
   localparam logic [OP_W-1:0] OP_OUT_DATE   = 4'd9;
   localparam logic [OP_W-1:0] OP_OUT_OVF    = 4'd10;
   localparam logic [OP_W-1:0] OP_OUT_DIFF   = 4'd11;
   localparam logic [OP_W-1:0] OP_OUT_ORDER  = 4'd12;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic action;       // latched action of the transaction
      logic order_err;    // second year below first year
      logic year_match;   // walking year reached the second year
      logic year_fits;    // remaining days cover the whole walking year
      logic year_at_max;  // walking year is the last allowed year
      logic month_more;   // remaining days cover the walking month
   } stat_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] n;
      case (m)
         4'd2:                      n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
      logic [DOY_W-1:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      if (leap && (m > 4'd2)) begin
         n = n + 9'd1;
      end
      return n;
   endfunction

   function automatic logic [MONTH_W-1:0] norm_month(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] n;
      n = m;
      if (m == '0) begin
         n = 4'd1;
      end else if (m > 4'd12) begin
         n = 4'd12;
      end
      return n;
   endfunction

endpackage

// File: rtl/cda_ctrl.sv
// Sequencer for the calendar date arithmetic block: walks the datapath through
// normalization, the year walk and the month walk. Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cda_pkg::stat_type stat,
   output cda_pkg::cmd_type  cmd
);
   import cda_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIVQ  = 3'd1;
   localparam logic [2:0] S_DIVR  = 3'd2;
   localparam logic [2:0] S_DOY   = 3'd3;
   localparam logic [2:0] S_DIFF  = 3'd4;
   localparam logic [2:0] S_YEAR  = 3'd5;
   localparam logic [2:0] S_MONTH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       pass1_ff, pass1_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      pass1_in = pass1_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               pass1_in = 1'b1;
               state_in = S_DIVQ;
            end
         end
         S_DIVQ: begin
            cmd.op   = OP_DIV_Q;
            state_in = S_DIVR;
         end
         S_DIVR: begin
            cmd.op   = OP_DIV_R;
            state_in = S_DOY;
         end
         S_DOY: begin
            // difference: second date goes first, then the walk starts at the first year
            if (pass1_ff && stat.action) begin
               cmd.op   = OP_DOY_SECOND;
               pass1_in = 1'b0;
               state_in = S_DIVQ;
            end else begin
               cmd.op   = OP_DOY_FIRST;
               state_in = stat.action ? S_DIFF : S_YEAR;
            end
         end
         S_DIFF: begin
            if (stat.order_err) begin
               cmd.op   = OP_OUT_ORDER;
               state_in = S_IDLE;
            end else if (stat.year_match) begin
               cmd.op   = OP_OUT_DIFF;
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_YEAR_DIFF;
            end
         end
         S_YEAR: begin
            if (!stat.year_fits) begin
               state_in = S_MONTH;
            end else if (stat.year_at_max) begin
               cmd.op   = OP_OUT_OVF;
               state_in = S_IDLE;
            end else begin
               cmd.op = OP_YEAR_ADD;
            end
         end
         S_MONTH: begin
            if (stat.month_more) begin
               cmd.op = OP_MONTH;
            end else begin
               cmd.op   = OP_OUT_DATE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass1_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass1_ff <= pass1_in;
      end
   end

endmodule

// File: rtl/cda_datapath.sv
// Datapath for the calendar date arithmetic block: date registers, the year/100 split,
// the day-of-year tables, the working day counter and the result registers. Depends on cda_pkg.
`timescale 1ns / 1ps

module cda_datapath #(
   parameter int MAX_YEAR = cda_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cda_pkg::cmd_type                cmd,
   output cda_pkg::stat_type               stat,
   input  logic                            req_action,
   input  logic [cda_pkg::DAY_W-1:0]       req_first_day,
   input  logic [cda_pkg::MONTH_W-1:0]     req_first_month,
   input  logic [cda_pkg::YEAR_IN_W-1:0]   req_first_year,
   input  logic [cda_pkg::DAY_W-1:0]       req_second_day,
   input  logic [cda_pkg::MONTH_W-1:0]     req_second_month,
   input  logic [cda_pkg::YEAR_IN_W-1:0]   req_second_year,
   input  logic [cda_pkg::CNT_W-1:0]       req_day_count,
   output logic                            rsp_valid,
   output logic [cda_pkg::DAY_W-1:0]       rsp_result_day,
   output logic [cda_pkg::MONTH_W-1:0]     rsp_result_month,
   output logic [cda_pkg::YEAR_IN_W-1:0]   rsp_result_year,
   output logic [cda_pkg::CNT_W-1:0]       rsp_result_days,
   output logic [cda_pkg::STATUS_W-1:0]    rsp_status
);
   import cda_pkg::*;

   localparam int YW = $clog2(MAX_YEAR + 1);
   localparam int CW = (YW > YEAR_IN_W) ? YW : YEAR_IN_W;
   localparam int PW = YW + DIV100_MUL_W;

   function automatic logic [YW-1:0] norm_year(input logic [YEAR_IN_W-1:0] y);
      logic [CW-1:0] t;
      t = CW'(y);
      if (t == '0) begin
         t = CW'(DEFAULT_YEAR);
      end
      if (t > CW'(MAX_YEAR)) begin
         t = CW'(MAX_YEAR);
      end
      return YW'(t);
   endfunction

   // operands
   logic                 act_ff;
   logic [DAY_W-1:0]     d0_ff, d1_ff;
   logic [MONTH_W-1:0]   m0_ff, m1_ff;
   logic [YW-1:0]        y0_ff, y1_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DOY_W-1:0]     doy0_ff, doy1_ff;
   // walking year with its quotient and remainder by 100
   logic [YW-1:0]        yw_ff;
   logic [YW-1:0]        qw_ff;
   logic [6:0]           rw_ff;
   logic [MONTH_W-1:0]   mw_ff;
   logic [WORK_W-1:0]    work_ff;
   // results
   logic                 valid_ff, valid_in;
   logic [DAY_W-1:0]     rday_ff;
   logic [MONTH_W-1:0]   rmonth_ff;
   logic [YEAR_IN_W-1:0] ryear_ff;
   logic [CNT_W-1:0]     rdays_ff;
   logic [STATUS_W-1:0]  rstat_ff;

   logic                 leap;
   logic [DOY_W-1:0]     ylen;
   logic [PW-1:0]        div_prod;
   logic [YW-1:0]        hund;
   logic                 sel2;
   logic [DAY_W-1:0]     sel_d, sel_dim, sel_dc;
   logic [MONTH_W-1:0]   sel_m;
   logic [DOY_W-1:0]     doy;
   logic [DAY_W-1:0]     wdim;
   logic [WORK_W-1:0]    acc_sum, acc_next;
   logic [WORK_W-1:0]    diff_tmp, diff_val;

   always_comb begin
      // y % 4 == y % 100 % 4; y % 400 == 0 when y % 100 == 0 and (y / 100) % 4 == 0
      leap = (rw_ff[1:0] == 2'b00) && ((rw_ff != 7'd0) || (qw_ff[1:0] == 2'b00));
      ylen = leap ? DOY_W'(366) : DOY_W'(365);

      div_prod = PW'(yw_ff) * PW'(DIV100_MUL);
      hund     = qw_ff * YW'(100);

      sel2    = (cmd.op == OP_DOY_SECOND);
      sel_d   = sel2 ? d1_ff : d0_ff;
      sel_m   = sel2 ? m1_ff : m0_ff;
      sel_dim = month_days(sel_m, leap);
      sel_dc  = (sel_d > sel_dim) ? sel_dim : sel_d;
      doy     = days_before(sel_m, leap) + DOY_W'(sel_dc) - DOY_W'(1);

      wdim = month_days(mw_ff, leap);

      acc_sum  = work_ff + WORK_W'(ylen);
      acc_next = (acc_sum > ACC_LIMIT) ? ACC_LIMIT : acc_sum;

      diff_tmp = work_ff + WORK_W'(doy1_ff);
      diff_val = diff_tmp - WORK_W'(doy0_ff);

      stat.action      = act_ff;
      stat.order_err   = (y1_ff < y0_ff);
      stat.year_match  = (yw_ff == y1_ff);
      stat.year_fits   = (work_ff >= WORK_W'(ylen));
      stat.year_at_max = (yw_ff == YW'(MAX_YEAR));
      stat.month_more  = (mw_ff < 4'd12) && (work_ff >= WORK_W'(wdim));

      valid_in = (cmd.op == OP_OUT_DATE) || (cmd.op == OP_OUT_OVF) ||
                 (cmd.op == OP_OUT_DIFF) || (cmd.op == OP_OUT_ORDER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            act_ff <= req_action;
            d0_ff  <= (req_first_day == '0) ? DAY_W'(1) : req_first_day;
            d1_ff  <= (req_second_day == '0) ? DAY_W'(1) : req_second_day;
            m0_ff  <= norm_month(req_first_month);
            m1_ff  <= norm_month(req_second_month);
            y0_ff  <= norm_year(req_first_year);
            y1_ff  <= norm_year(req_second_year);
            cnt_ff <= req_day_count;
            yw_ff  <= req_action ? norm_year(req_second_year) : norm_year(req_first_year);
         end
         OP_DIV_Q: begin
            qw_ff <= YW'(div_prod >> DIV100_SHIFT);
         end
         OP_DIV_R: begin
            rw_ff <= 7'(yw_ff - hund);
         end
         OP_DOY_SECOND: begin
            doy1_ff <= doy;
            yw_ff   <= y0_ff;
         end
         OP_DOY_FIRST: begin
            doy0_ff <= doy;
            mw_ff   <= MONTH_W'(1);
            work_ff <= act_ff ? '0 : (WORK_W'(doy) + WORK_W'(cnt_ff));
         end
         OP_YEAR_ADD, OP_YEAR_DIFF: begin
            work_ff <= (cmd.op == OP_YEAR_ADD) ? (work_ff - WORK_W'(ylen)) : acc_next;
            yw_ff   <= yw_ff + YW'(1);
            if (rw_ff == 7'd99) begin
               rw_ff <= 7'd0;
               qw_ff <= qw_ff + YW'(1);
            end else begin
               rw_ff <= rw_ff + 7'd1;
            end
         end
         OP_MONTH: begin
            work_ff <= work_ff - WORK_W'(wdim);
            mw_ff   <= mw_ff + MONTH_W'(1);
         end
         OP_OUT_DATE: begin
            rday_ff   <= DAY_W'(work_ff) + DAY_W'(1);
            rmonth_ff <= mw_ff;
            ryear_ff  <= YEAR_IN_W'(yw_ff);
            rdays_ff  <= '0;
            rstat_ff  <= ST_OK;
         end
         OP_OUT_OVF: begin
            rday_ff   <= DAY_W'(31);
            rmonth_ff <= MONTH_W'(12);
            ryear_ff  <= YEAR_IN_W'(MAX_YEAR);
            rdays_ff  <= '0;
            rstat_ff  <= ST_OVF;
         end
         OP_OUT_DIFF: begin
            rday_ff   <= '0;
            rmonth_ff <= '0;
            ryear_ff  <= '0;
            // same year with the second day earlier in it
            if (diff_tmp < WORK_W'(doy0_ff)) begin
               rdays_ff <= '0;
               rstat_ff <= ST_ORDER;
            end else begin
               rdays_ff <= (diff_val > WORK_W'(DAYS_MAX)) ? DAYS_MAX : CNT_W'(diff_val);
               rstat_ff <= ST_OK;
            end
         end
         OP_OUT_ORDER: begin
            rday_ff   <= '0;
            rmonth_ff <= '0;
            ryear_ff  <= '0;
            rdays_ff  <= '0;
            rstat_ff  <= ST_ORDER;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_day   = rday_ff;
   assign rsp_result_month = rmonth_ff;
   assign rsp_result_year  = ryear_ff;
   assign rsp_result_days  = rdays_ff;
   assign rsp_status       = rstat_ff;

endmodule

// File: rtl/calendar_date_arithmetic.sv
// Top level of the calendar date arithmetic block: sequencer plus datapath.
// Depends on cda_pkg, cda_ctrl and cda_datapath.
//
// Gregorian date arithmetic, one transaction at a time. A transaction is taken
// when start is high and busy is low; its single result appears for exactly one
// cycle with rsp_valid high, and the receiver must take it then. Action 0 adds
// req_day_count days to the first date, action 1 gives the days from the first
// date to the second. The sequencer walks one year per cycle and then one month
// per cycle. An add crosses whole years (at most MAX_YEAR - 1, since the walk
// stops with the overflow status instead of passing MAX_YEAR) while the
// remaining days cover the walking year, then months of the last year (at most
// 11). A difference walks from the first year up to the second, and ends with
// the order status without a walk when the second year is earlier. busy drops
// in the cycle the result is shown, so the next transaction can start then.
`timescale 1ns / 1ps

module calendar_date_arithmetic #(
   parameter int MAX_YEAR = cda_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [cda_pkg::DAY_W-1:0]       req_first_day,
   input  logic [cda_pkg::MONTH_W-1:0]     req_first_month,
   input  logic [cda_pkg::YEAR_IN_W-1:0]   req_first_year,
   input  logic [cda_pkg::DAY_W-1:0]       req_second_day,
   input  logic [cda_pkg::MONTH_W-1:0]     req_second_month,
   input  logic [cda_pkg::YEAR_IN_W-1:0]   req_second_year,
   input  logic [cda_pkg::CNT_W-1:0]       req_day_count,
   output logic                            rsp_valid,
   output logic [cda_pkg::DAY_W-1:0]       rsp_result_day,
   output logic [cda_pkg::MONTH_W-1:0]     rsp_result_month,
   output logic [cda_pkg::YEAR_IN_W-1:0]   rsp_result_year,
   output logic [cda_pkg::CNT_W-1:0]       rsp_result_days,
   output logic [cda_pkg::STATUS_W-1:0]    rsp_status
);
   import cda_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cda_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cda_datapath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_first_day    (req_first_day),
      .req_first_month  (req_first_month),
      .req_first_year   (req_first_year),
      .req_second_day   (req_second_day),
      .req_second_month (req_second_month),
      .req_second_year  (req_second_year),
      .req_day_count    (req_day_count),
      .rsp_valid        (rsp_valid),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_days  (rsp_result_days),
      .rsp_status       (rsp_status)
   );

endmodule
